FILE: rtl/core/ttg_pkg.sv
// ----------------------------------------------------------------------------
// ttg_pkg
// shared types and constants of the triangle tangent generator
// ----------------------------------------------------------------------------
package ttg_pkg;

    // partial product digit of the edge/uv multiplier
    localparam int DIGW = 16;

    // normalized component width and fraction bits of the result
    localparam int CW   = 24;
    localparam int FRAC = 15;
    localparam int TW   = 16;               // tangent component width
    localparam int QW   = 16;               // raw quotient bits
    localparam int QMW  = 15;               // saturated quotient magnitude
    localparam logic [QW-1:0] QMAX = 16'h7fff;

    // sum of squares, square root and divider widths
    localparam int SW   = 2 * CW + 2;       // sum of three squares
    localparam int SQW  = SW + 1;           // root trial width
    localparam int LW   = CW + 1;           // root (length) width
    localparam int NW   = CW + FRAC + 1;    // rounded dividend width

    typedef enum logic [2:0] {
        T_IDLE,
        T_MAC,
        T_EVAL,
        T_NSTART,
        T_NWAIT,
        T_LOAD
    } ttg_state_t;

    typedef enum logic [2:0] {
        N_IDLE,
        N_SHIFT,
        N_SQ,
        N_SQRT,
        N_DIVLD,
        N_DIV,
        N_DONE
    } ttg_nstate_t;

    typedef struct packed {
        logic done;
        logic zero;
    } ttg_norm_stat_t;

endpackage

FILE: rtl/core/ttg_corner_if.sv
// ----------------------------------------------------------------------------
// ttg_corner_if
// corner channel: vertex index, position and texture coordinate
// ----------------------------------------------------------------------------
interface ttg_corner_if #(
    parameter int INDEX_WIDTH = 32,
    parameter int COORD_WIDTH = 32
) ();
    logic                          valid;
    logic                          ready;
    logic        [INDEX_WIDTH-1:0] corner_index;
    logic signed [COORD_WIDTH-1:0] pos_x;
    logic signed [COORD_WIDTH-1:0] pos_y;
    logic signed [COORD_WIDTH-1:0] pos_z;
    logic signed [COORD_WIDTH-1:0] tex_u;
    logic signed [COORD_WIDTH-1:0] tex_v;

    modport source (
        output valid, corner_index, pos_x, pos_y, pos_z, tex_u, tex_v,
        input  ready
    );

    modport sink (
        input  valid, corner_index, pos_x, pos_y, pos_z, tex_u, tex_v,
        output ready
    );
endinterface

FILE: rtl/core/ttg_result_if.sv
// ----------------------------------------------------------------------------
// ttg_result_if
// result channel: target vertex index and unit tangent
// ----------------------------------------------------------------------------
interface ttg_result_if #(
    parameter int INDEX_WIDTH = 32
) ();
    logic                   valid;
    logic                   ready;
    logic [INDEX_WIDTH-1:0] target_index;
    logic signed [15:0]     tangent_x;
    logic signed [15:0]     tangent_y;
    logic signed [15:0]     tangent_z;
    logic                   degenerate;
    logic                   last_of_triangle;

    modport source (
        output valid, target_index, tangent_x, tangent_y, tangent_z,
               degenerate, last_of_triangle,
        input  ready
    );

    modport sink (
        input  valid, target_index, tangent_x, tangent_y, tangent_z,
               degenerate, last_of_triangle,
        output ready
    );
endinterface

FILE: rtl/core/ttg_norm.sv
// ----------------------------------------------------------------------------
// ttg_norm
// iterative normalizer: leading-one shift, sum of squares, integer square
// root and rounded restoring division, one step per cycle
// ----------------------------------------------------------------------------
module ttg_norm
    import ttg_pkg::*;
#(
    parameter int MAG_WIDTH = 66
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [MAG_WIDTH-1:0] mag [3],
    output ttg_norm_stat_t       stat,
    output logic [QMW-1:0]       q [3]
);

    localparam int STW = $clog2(QW);

    ttg_nstate_t          state_reg, state_next;
    logic [MAG_WIDTH-1:0] m_reg [3];
    logic [MAG_WIDTH-1:0] m_next [3];
    logic [1:0]           cnt_reg, cnt_next;
    logic                 zero_reg, zero_next;
    logic [SW-1:0]        s_reg, s_next;
    logic [SQW-1:0]       x_reg, x_next;
    logic [SQW-1:0]       r_reg, r_next;
    logic [SQW-1:0]       bit_reg, bit_next;
    logic [LW-1:0]        len_reg, len_next;
    logic [LW-1:0]        rem_reg, rem_next;
    logic [QW-1:0]        nlo_reg, nlo_next;
    logic [QW-1:0]        qsh_reg, qsh_next;
    logic [STW-1:0]       step_reg, step_next;
    logic [QMW-1:0]       q_reg [3];
    logic [QMW-1:0]       q_next [3];

    logic [MAG_WIDTH-1:0] m_or;
    logic [MAG_WIDTH-1:0] mag_or;
    logic [CW-1:0]        c_sel;
    logic [2*CW-1:0]      sq;
    logic [SW-1:0]        s_sum;
    logic [SQW-1:0]       trial;
    logic [SQW-1:0]       r_step;
    logic [NW-1:0]        num;
    logic [LW:0]          rem2;
    logic                 ge;

    assign m_or   = m_reg[0] | m_reg[1] | m_reg[2];
    assign mag_or = mag[0] | mag[1] | mag[2];
    assign c_sel  = m_reg[cnt_reg][MAG_WIDTH-1 -: CW];
    assign sq     = c_sel * c_sel;
    assign s_sum  = s_reg + SW'(sq);
    assign trial  = r_reg + bit_reg;
    assign num    = {1'b0, c_sel, {FRAC{1'b0}}} + NW'(len_reg >> 1);
    assign rem2   = {rem_reg, nlo_reg[QW-1]};
    assign ge     = rem2 >= {1'b0, len_reg};
    assign q      = q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= N_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg    <= m_next;
        cnt_reg  <= cnt_next;
        zero_reg <= zero_next;
        s_reg    <= s_next;
        x_reg    <= x_next;
        r_reg    <= r_next;
        bit_reg  <= bit_next;
        len_reg  <= len_next;
        rem_reg  <= rem_next;
        nlo_reg  <= nlo_next;
        qsh_reg  <= qsh_next;
        step_reg <= step_next;
        q_reg    <= q_next;
    end

    always_comb
    begin
        state_next = state_reg;
        m_next     = m_reg;
        cnt_next   = cnt_reg;
        zero_next  = zero_reg;
        s_next     = s_reg;
        x_next     = x_reg;
        r_next     = r_reg;
        bit_next   = bit_reg;
        len_next   = len_reg;
        rem_next   = rem_reg;
        nlo_next   = nlo_reg;
        qsh_next   = qsh_reg;
        step_next  = step_reg;
        q_next     = q_reg;
        r_step     = '0;
        stat       = '0;

        unique case (state_reg)
            N_IDLE:
            begin
                if (start)
                begin
                    m_next = mag;
                    if (mag_or == '0)
                    begin
                        zero_next  = 1'b1;
                        state_next = N_DONE;
                    end
                    else
                    begin
                        zero_next  = 1'b0;
                        state_next = N_SHIFT;
                    end
                end
            end

            N_SHIFT:
            begin
                // bring the largest component up to the top bit
                if (m_or[MAG_WIDTH-1])
                begin
                    cnt_next   = '0;
                    s_next     = '0;
                    state_next = N_SQ;
                end
                else if (m_or[MAG_WIDTH-1 -: 8] == '0)
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        m_next[k] = m_reg[k] << 8;
                    end
                end
                else
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        m_next[k] = m_reg[k] << 1;
                    end
                end
            end

            N_SQ:
            begin
                s_next = s_sum;
                if (cnt_reg == 2'd2)
                begin
                    x_next     = SQW'(s_sum);
                    r_next     = '0;
                    bit_next   = SQW'(1) << SW;
                    state_next = N_SQRT;
                end
                else
                begin
                    cnt_next = cnt_reg + 2'd1;
                end
            end

            N_SQRT:
            begin
                // each step takes a pair of bits of the radicand and settles the next root bit
                if (x_reg >= trial)
                begin
                    x_next = x_reg - trial;
                    r_step = (r_reg >> 1) + bit_reg;
                end
                else
                begin
                    r_step = r_reg >> 1;
                end
                r_next   = r_step;
                bit_next = bit_reg >> 2;
                if (bit_reg[0])
                begin
                    len_next   = r_step[LW-1:0];
                    cnt_next   = '0;
                    state_next = N_DIVLD;
                end
            end

            N_DIVLD:
            begin
                // quotient fits in QW bits, so the upper dividend starts as remainder
                rem_next   = LW'(num[NW-1:QW]);
                nlo_next   = num[QW-1:0];
                qsh_next   = '0;
                step_next  = '0;
                state_next = N_DIV;
            end

            N_DIV:
            begin
                rem_next  = ge ? LW'(rem2 - {1'b0, len_reg}) : LW'(rem2);
                qsh_next  = {qsh_reg[QW-2:0], ge};
                nlo_next  = nlo_reg << 1;
                step_next = step_reg + STW'(1);
                if (step_reg == STW'(QW - 1))
                begin
                    q_next[cnt_reg] = (qsh_next > QMAX) ? QMAX[QMW-1:0] : qsh_next[QMW-1:0];
                    if (cnt_reg == 2'd2)
                    begin
                        state_next = N_DONE;
                    end
                    else
                    begin
                        cnt_next   = cnt_reg + 2'd1;
                        state_next = N_DIVLD;
                    end
                end
            end

            N_DONE:
            begin
                stat.done  = 1'b1;
                stat.zero  = zero_reg;
                state_next = N_IDLE;
            end

            default:
            begin
                state_next = N_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/core/triangle_tangent_generator.sv
// ----------------------------------------------------------------------------
// triangle_tangent_generator
// per-triangle unit tangent from corner positions and texture coordinates
// ----------------------------------------------------------------------------
// usage
//   corner channel (sink): one item per triangle corner, three per triangle.
//   the first two corners are taken while idle and only held.
//   the third corner starts the computation; ready stays low until the
//   tangent has been moved into the output buffer.
//   result channel (source): three items per triangle, one per corner
//   index in corner order, the third with last_of_triangle set.
// sequence
//   multiply-accumulate through one shared digit multiplier, then the
//   leading-one shift, the squares, the root steps, the divide steps for
//   each component and the handover to the output buffer; a zero uv
//   determinant skips the normalizer. at the default widths the root and
//   divide loop is the longest part of this sequence from the third corner
//   to the first result.
// next triangle
//   a new triangle is taken only once the previous tangent is in the buffer.
// reset
//   rst_n clears the corner count, the sequencers and the output buffer.
// stall
//   results wait in the output buffer; the first two corners of the next
//   triangle are still taken, and a finished triangle waits for the buffer.
// ----------------------------------------------------------------------------
module triangle_tangent_generator
    import ttg_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    parameter int INDEX_WIDTH = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    ttg_corner_if.sink   corner,
    ttg_result_if.source result
);

    localparam int C    = COORD_WIDTH;
    localparam int DW   = C + 1;                 // coordinate difference
    localparam int NDIG = (DW + DIGW - 1) / DIGW;
    localparam int DGW  = $clog2(NDIG);
    localparam int AW   = 2 * C + 3;             // exact product sums
    localparam int MW   = AW - 1;                // their magnitudes

    // exact difference of two coordinates
    function automatic logic signed [DW-1:0] sdiff(
        input logic signed [C-1:0] a,
        input logic signed [C-1:0] b
    );
        return DW'(a) - DW'(b);
    endfunction

    // control
    ttg_state_t      state_reg, state_next;
    logic [1:0]      corner_count_reg, corner_count_next;
    logic [2:0]      prod_reg, prod_next;
    logic [DGW-1:0]  dig_reg, dig_next;
    logic            deg_reg, deg_next;
    logic            ob_busy_reg, ob_busy_next;
    logic [1:0]      ob_cnt_reg, ob_cnt_next;

    // accumulator and products: det, then tangent x, y, z
    logic [AW-1:0]   acc_reg, acc_next;
    logic [AW-1:0]   res_reg [4];
    logic [AW-1:0]   res_next [4];

    // held corners and differences
    logic signed [C-1:0]  px_reg [2];
    logic signed [C-1:0]  py_reg [2];
    logic signed [C-1:0]  pz_reg [2];
    logic signed [C-1:0]  tu_reg [2];
    logic signed [C-1:0]  tv_reg [2];
    logic [INDEX_WIDTH-1:0] idx_reg [2];
    logic [INDEX_WIDTH-1:0] idx2_reg;
    logic signed [DW-1:0] du1_reg, dv1_reg, du2_reg, dv2_reg;
    logic signed [DW-1:0] e1_reg [3];
    logic signed [DW-1:0] e2_reg [3];

    // output buffer
    logic [INDEX_WIDTH-1:0] ob_idx_reg [3];
    logic signed [TW-1:0]   ob_tan_reg [3];
    logic                   ob_deg_reg;

    logic            in_ready;
    logic            in_acc;
    logic            out_acc;
    logic            ob_load;
    logic            norm_start;
    ttg_norm_stat_t  norm_stat;
    logic [QMW-1:0]  norm_q [3];
    logic [MW-1:0]   norm_mag [3];

    logic signed [DW-1:0]     a_s, b_s;
    logic [DW-1:0]            a_mag, b_mag;
    logic [NDIG*DIGW-1:0]     b_ext;
    logic [DIGW-1:0]          digit;
    logic [DW+DIGW-1:0]       pp_raw;
    logic [AW-1:0]            pp_sh;
    logic                     pp_neg;
    logic [AW-1:0]            acc_sum;

    assign in_ready     = (state_reg == T_IDLE);
    assign corner.ready = in_ready;
    assign in_acc       = corner.valid && in_ready;
    assign out_acc      = result.valid && result.ready;

    // ---------------------------------------------------------------- operands
    // even steps add, odd steps subtract: det = du1*dv2 - du2*dv1,
    // t[k] = dv2*e1[k] - dv1*e2[k]
    always_comb
    begin
        unique case (prod_reg)
            3'd0:    begin a_s = du1_reg; b_s = dv2_reg;   end
            3'd1:    begin a_s = du2_reg; b_s = dv1_reg;   end
            3'd2:    begin a_s = dv2_reg; b_s = e1_reg[0]; end
            3'd3:    begin a_s = dv1_reg; b_s = e2_reg[0]; end
            3'd4:    begin a_s = dv2_reg; b_s = e1_reg[1]; end
            3'd5:    begin a_s = dv1_reg; b_s = e2_reg[1]; end
            3'd6:    begin a_s = dv2_reg; b_s = e1_reg[2]; end
            default: begin a_s = dv1_reg; b_s = e2_reg[2]; end
        endcase
    end

    assign a_mag   = a_s[DW-1] ? DW'(-a_s) : DW'(a_s);
    assign b_mag   = b_s[DW-1] ? DW'(-b_s) : DW'(b_s);
    assign b_ext   = (NDIG*DIGW)'(b_mag);
    assign digit   = b_ext[dig_reg*DIGW +: DIGW];
    assign pp_raw  = (DW+DIGW)'(a_mag) * (DW+DIGW)'(digit);
    assign pp_sh   = AW'(pp_raw) << (dig_reg * DIGW);
    assign pp_neg  = a_s[DW-1] ^ b_s[DW-1] ^ prod_reg[0];
    assign acc_sum = pp_neg ? (acc_reg - pp_sh) : (acc_reg + pp_sh);

    // tangent magnitudes for the normalizer
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            norm_mag[k] = res_reg[k+1][AW-1] ? MW'(-res_reg[k+1]) : MW'(res_reg[k+1]);
        end
    end

    ttg_norm #(
        .MAG_WIDTH (MW)
    ) u_norm (
        .clk   (clk),
        .rst_n (rst_n),
        .start (norm_start),
        .mag   (norm_mag),
        .stat  (norm_stat),
        .q     (norm_q)
    );

    // ---------------------------------------------------------------- control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= T_IDLE;
            corner_count_reg <= '0;
            ob_busy_reg      <= 1'b0;
            ob_cnt_reg       <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            corner_count_reg <= corner_count_next;
            ob_busy_reg      <= ob_busy_next;
            ob_cnt_reg       <= ob_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        dig_reg  <= dig_next;
        deg_reg  <= deg_next;
        acc_reg  <= acc_next;
        res_reg  <= res_next;
    end

    always_comb
    begin
        state_next        = state_reg;
        corner_count_next = corner_count_reg;
        prod_next         = prod_reg;
        dig_next          = dig_reg;
        deg_next          = deg_reg;
        acc_next          = acc_reg;
        res_next          = res_reg;
        norm_start        = 1'b0;
        ob_load           = 1'b0;

        unique case (state_reg)
            T_IDLE:
            begin
                if (in_acc)
                begin
                    if (corner_count_reg != 2'd2)
                    begin
                        corner_count_next = corner_count_reg + 2'd1;
                    end
                    else
                    begin
                        corner_count_next = '0;
                        prod_next         = '0;
                        dig_next          = '0;
                        acc_next          = '0;
                        state_next        = T_MAC;
                    end
                end
            end

            T_MAC:
            begin
                acc_next = acc_sum;
                dig_next = dig_reg + DGW'(1);
                if (dig_reg == DGW'(NDIG - 1))
                begin
                    dig_next  = '0;
                    prod_next = prod_reg + 3'd1;
                    if (prod_reg[0])
                    begin
                        // pair done: store and start the next sum
                        res_next[prod_reg[2:1]] = acc_sum;
                        acc_next                = '0;
                        if (prod_reg == 3'd7)
                        begin
                            state_next = T_EVAL;
                        end
                    end
                end
            end

            T_EVAL:
            begin
                if (res_reg[0] == '0)
                begin
                    deg_next   = 1'b1;
                    state_next = T_LOAD;
                end
                else
                begin
                    deg_next   = 1'b0;
                    state_next = T_NSTART;
                end
            end

            T_NSTART:
            begin
                norm_start = 1'b1;
                state_next = T_NWAIT;
            end

            T_NWAIT:
            begin
                if (norm_stat.done)
                begin
                    deg_next   = norm_stat.zero;
                    state_next = T_LOAD;
                end
            end

            T_LOAD:
            begin
                if (!ob_busy_reg)
                begin
                    ob_load    = 1'b1;
                    state_next = T_IDLE;
                end
            end

            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------- corner hold
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            if (corner_count_reg != 2'd2)
            begin
                px_reg[corner_count_reg[0]]  <= corner.pos_x;
                py_reg[corner_count_reg[0]]  <= corner.pos_y;
                pz_reg[corner_count_reg[0]]  <= corner.pos_z;
                tu_reg[corner_count_reg[0]]  <= corner.tex_u;
                tv_reg[corner_count_reg[0]]  <= corner.tex_v;
                idx_reg[corner_count_reg[0]] <= corner.corner_index;
            end
            else
            begin
                // third corner: edges and uv deltas against corner 0
                idx2_reg  <= corner.corner_index;
                du1_reg   <= sdiff(tu_reg[1], tu_reg[0]);
                dv1_reg   <= sdiff(tv_reg[1], tv_reg[0]);
                du2_reg   <= sdiff(corner.tex_u, tu_reg[0]);
                dv2_reg   <= sdiff(corner.tex_v, tv_reg[0]);
                e1_reg[0] <= sdiff(px_reg[1], px_reg[0]);
                e1_reg[1] <= sdiff(py_reg[1], py_reg[0]);
                e1_reg[2] <= sdiff(pz_reg[1], pz_reg[0]);
                e2_reg[0] <= sdiff(corner.pos_x, px_reg[0]);
                e2_reg[1] <= sdiff(corner.pos_y, py_reg[0]);
                e2_reg[2] <= sdiff(corner.pos_z, pz_reg[0]);
            end
        end
    end

    // ---------------------------------------------------------------- output buffer
    always_comb
    begin
        ob_busy_next = ob_busy_reg;
        ob_cnt_next  = ob_cnt_reg;
        if (ob_load)
        begin
            ob_busy_next = 1'b1;
            ob_cnt_next  = '0;
        end
        else if (out_acc)
        begin
            if (ob_cnt_reg == 2'd2)
            begin
                ob_busy_next = 1'b0;
            end
            else
            begin
                ob_cnt_next = ob_cnt_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ob_load)
        begin
            ob_idx_reg[0] <= idx_reg[0];
            ob_idx_reg[1] <= idx_reg[1];
            ob_idx_reg[2] <= idx2_reg;
            ob_deg_reg    <= deg_reg;
            for (int k = 0; k < 3; k++)
            begin
                // component sign times the sign of the uv determinant
                if (deg_reg)
                begin
                    ob_tan_reg[k] <= '0;
                end
                else if (res_reg[k+1][AW-1] ^ res_reg[0][AW-1])
                begin
                    ob_tan_reg[k] <= -$signed({1'b0, norm_q[k]});
                end
                else
                begin
                    ob_tan_reg[k] <= $signed({1'b0, norm_q[k]});
                end
            end
        end
    end

    assign result.valid            = ob_busy_reg;
    assign result.target_index     = ob_idx_reg[ob_cnt_reg];
    assign result.tangent_x        = ob_tan_reg[0];
    assign result.tangent_y        = ob_tan_reg[1];
    assign result.tangent_z        = ob_tan_reg[2];
    assign result.degenerate       = ob_deg_reg;
    assign result.last_of_triangle = (ob_cnt_reg == 2'd2);

    // ---------------------------------------------------------------- checks
    // the buffer never points past the third result
    a_ob_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (ob_cnt_reg != 2'd3))
        else $error("output buffer count out of range");

    // the buffer is empty right after the last result of a triangle
    a_last_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (out_acc && result.last_of_triangle) |=> !result.valid)
        else $error("result valid after last item of triangle");

    // a third corner always starts the multiply sequence
    a_third_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (corner_count_reg == 2'd2)) |=> (state_reg == T_MAC))
        else $error("third corner did not start the tangent sequence");

    // the normalizer only finishes while the sequencer waits for it
    a_norm_done: assert property (@(posedge clk) disable iff (!rst_n)
        norm_stat.done |-> (state_reg == T_NWAIT))
        else $error("normalizer finished outside its wait state");

endmodule

FILE: tb/sv/tb_triangle_tangent_generator.sv
// ----------------------------------------------------------------------------
// tb_triangle_tangent_generator
// self-checking bench for the per-triangle tangent generator
// ----------------------------------------------------------------------------
// corners are streamed in groups of three over the corner channel. a model
// of the block, kept inside this bench, turns every completed triangle into
// three expected tangent items, which are checked in order against the result
// channel. a short table of hand-built triangles (unit axes, mirrored uv,
// index extremes, the degenerate cases, full-scale coordinates) comes first.
// then random triangles of mixed magnitude and shape follow. both channels
// idle at random, and the result side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_triangle_tangent_generator
    import ttg_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD       = 4;
    localparam int RESET_CYCLES     = 12;
    localparam int RANDOM_TRIANGLES = 167;     // about 500 corner items
    localparam int DRAIN_CYCLES     = 200;     // wait for strays after the last expected item
    localparam int PRESSURE_AFTER   = 60;      // results seen before the long hold-off
    localparam int PRESSURE_CYCLES  = 600;
    localparam int TIMEOUT_NS       = 2_000_000;

    // handy q16.16 values and the saturated q1.15 unit
    localparam logic signed [31:0] ONE_Q16   = 32'sh0001_0000;
    localparam logic signed [31:0] COORD_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] COORD_MAX = 32'sh7fff_ffff;
    localparam logic signed [TW-1:0] UNIT_POS = 16'sh7fff;
    localparam logic signed [TW-1:0] UNIT_NEG = 16'sh8001;

    typedef struct packed {
        logic        [31:0] idx;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic signed [31:0] tu;
        logic signed [31:0] tv;
    } corner_t;

    typedef struct packed {
        logic signed [TW-1:0] tx;
        logic signed [TW-1:0] ty;
        logic signed [TW-1:0] tz;
        logic                 deg;
    } tangent_t;

    typedef struct packed {
        logic        [31:0]   idx;
        logic signed [TW-1:0] tx;
        logic signed [TW-1:0] ty;
        logic signed [TW-1:0] tz;
        logic                 deg;
        logic                 last;
    } tangent_result_t;

    // one directed triangle; typed rows carry the tangent read off by hand
    typedef struct packed {
        corner_t  c0;
        corner_t  c1;
        corner_t  c2;
        logic     typed;
        tangent_t want;
    } triangle_row_t;

    logic clk = 1'b0;
    logic rst_n;

    ttg_corner_if #(.INDEX_WIDTH(32), .COORD_WIDTH(32)) corner_ch ();
    ttg_result_if #(.INDEX_WIDTH(32)) result_ch ();

    triangle_tangent_generator #(
        .COORD_WIDTH(32),
        .INDEX_WIDTH(32)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .corner (corner_ch),
        .result (result_ch)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // expected tangent items, oldest first
    tangent_result_t pending_tangents[$];
    int              mismatch_count = 0;

    // model state: corners taken so far and the two held corners
    int                 corners_held = 0;
    logic signed [31:0] held_pos[2][3];
    logic signed [31:0] held_tex[2][2];
    logic        [31:0] held_idx[2];

    // takes one corner; on the third one returns 1 with the tangent and
    // the three target indices of the triangle
    function automatic bit predict_corner(input corner_t c, output tangent_t tan,
                                          output logic [2:0][31:0] targets);
        logic signed [79:0] du1, dv1, du2, dv2, det, e1, e2;
        logic signed [79:0] tvec[3];
        logic        [79:0] mag[3];
        logic        [63:0] comp[3];
        logic        [63:0] sumsq, root, trial, quot;
        logic signed [31:0] p2[3];
        logic signed [TW-1:0] q16[3];
        int top, k, b;
        tan = '0;
        targets = '0;
        if (corners_held < 2) begin
            held_pos[corners_held][0] = c.px;
            held_pos[corners_held][1] = c.py;
            held_pos[corners_held][2] = c.pz;
            held_tex[corners_held][0] = c.tu;
            held_tex[corners_held][1] = c.tv;
            held_idx[corners_held]    = c.idx;
            corners_held++;
            return 1'b0;
        end
        corners_held = 0;
        p2[0] = c.px;
        p2[1] = c.py;
        p2[2] = c.pz;

        // exact edges, uv deltas, determinant and unnormalized tangent
        du1 = held_tex[1][0] - held_tex[0][0];
        dv1 = held_tex[1][1] - held_tex[0][1];
        du2 = c.tu - held_tex[0][0];
        dv2 = c.tv - held_tex[0][1];
        det = du1 * dv2 - du2 * dv1;
        for (k = 0; k < 3; k++) begin
            e1 = held_pos[1][k] - held_pos[0][k];
            e2 = p2[k] - held_pos[0][k];
            tvec[k] = dv2 * e1 - dv1 * e2;
        end

        tan.deg = (det == 0);
        if (!tan.deg) begin
            top = 0;
            for (k = 0; k < 3; k++) begin
                mag[k] = (tvec[k] < 0) ? -tvec[k] : tvec[k];
                for (b = 0; b < 80; b++)
                    if (mag[k][b] && b + 1 > top)
                        top = b + 1;
            end
            if (top == 0) begin
                // uv fine but the vector vanished
                tan.deg = 1'b1;
            end
            else begin
                // bring the largest magnitude into [2^23, 2^24), truncating
                for (k = 0; k < 3; k++)
                    comp[k] = (top > CW) ? 64'(mag[k] >> (top - CW))
                                         : 64'(mag[k] << (CW - top));
                sumsq = comp[0] * comp[0] + comp[1] * comp[1] + comp[2] * comp[2];
                // floor of the square root, one bit at a time
                root = '0;
                for (b = 25; b >= 0; b--) begin
                    trial = root | (64'd1 << b);
                    if (trial * trial <= sumsq)
                        root = trial;
                end
                for (k = 0; k < 3; k++) begin
                    quot = ((comp[k] << FRAC) + (root >> 1)) / root;
                    if (quot > 64'(QMAX))
                        quot = 64'(QMAX);
                    q16[k] = ((tvec[k] < 0) ^ (det < 0)) ? -quot[TW-1:0] : quot[TW-1:0];
                end
                tan.tx = q16[0];
                tan.ty = q16[1];
                tan.tz = q16[2];
            end
        end
        targets[0] = held_idx[0];
        targets[1] = held_idx[1];
        targets[2] = c.idx;
        return 1'b1;
    endfunction

    function automatic corner_t make_corner(input logic [31:0] idx,
                                            input logic signed [31:0] px, py, pz,
                                            input logic signed [31:0] tu, tv);
        corner_t c;
        c.idx = idx;
        c.px  = px;
        c.py  = py;
        c.pz  = pz;
        c.tu  = tu;
        c.tv  = tv;
        return c;
    endfunction

    // coordinate of a chosen flavor: full range, small, or an extreme
    function automatic logic signed [31:0] rand_coord(input int mode);
        logic [31:0] mag;
        case (mode)
            0: return $urandom;
            1:
            begin
                mag = $urandom & ((32'd1 << $urandom_range(1, 20)) - 32'd1);
                return $urandom_range(0, 1) ? -$signed(mag) : $signed(mag);
            end
            default:
            begin
                case ($urandom_range(0, 5))
                    0: return COORD_MIN;
                    1: return COORD_MAX;
                    2: return 32'sd0;
                    3: return ONE_Q16;
                    4: return -ONE_Q16;
                    default: return -32'sd1;
                endcase
            end
        endcase
    endfunction

    // sender gap: mostly back to back, sometimes short, rarely long
    function automatic int sender_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // offer one corner item, wait for the handshake, record what it causes
    task automatic push_corner(input corner_t c, input int gap, input bit typed,
                               input tangent_t typed_tan);
        tangent_t          tan;
        logic [2:0][31:0]  targets;
        tangent_result_t   exp_item;
        int                k;
        if (gap > 0) begin
            corner_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        corner_ch.valid        <= 1'b1;
        corner_ch.corner_index <= c.idx;
        corner_ch.pos_x        <= c.px;
        corner_ch.pos_y        <= c.py;
        corner_ch.pos_z        <= c.pz;
        corner_ch.tex_u        <= c.tu;
        corner_ch.tex_v        <= c.tv;
        do @(posedge clk); while (!corner_ch.ready);
        if (predict_corner(c, tan, targets)) begin
            if (typed)
                tan = typed_tan;
            for (k = 0; k < 3; k++) begin
                exp_item.idx  = targets[k];
                exp_item.tx   = tan.tx;
                exp_item.ty   = tan.ty;
                exp_item.tz   = tan.tz;
                exp_item.deg  = tan.deg;
                exp_item.last = (k == 2);
                pending_tangents = {pending_tangents, exp_item};
            end
        end
    endtask

    // compare one accepted result item with the oldest expectation
    task automatic check_tangent(input tangent_result_t got);
        tangent_result_t want;
        if (pending_tangents.size() == 0) begin
            $error("result item with no expected tangent pending (index %0d)", got.idx);
            mismatch_count++;
        end
        else begin
            want = pending_tangents.pop_front();
            if (got.idx !== want.idx) begin
                $error("target_index: expected %0d, got %0d", want.idx, got.idx);
                mismatch_count++;
            end
            if (got.tx !== want.tx) begin
                $error("tangent_x: expected %0d, got %0d", want.tx, got.tx);
                mismatch_count++;
            end
            if (got.ty !== want.ty) begin
                $error("tangent_y: expected %0d, got %0d", want.ty, got.ty);
                mismatch_count++;
            end
            if (got.tz !== want.tz) begin
                $error("tangent_z: expected %0d, got %0d", want.tz, got.tz);
                mismatch_count++;
            end
            if (got.deg !== want.deg) begin
                $error("degenerate: expected %0d, got %0d", want.deg, got.deg);
                mismatch_count++;
            end
            if (got.last !== want.last) begin
                $error("last_of_triangle: expected %0d, got %0d", want.last, got.last);
                mismatch_count++;
            end
        end
    endtask

    // result side: random ready, calm stretches, one long hold-off
    initial begin : result_sink
        tangent_result_t got;
        int  stall_left;
        int  calm_left;
        int  roll;
        int  results_seen;
        bit  pressure_done;
        stall_left    = 0;
        calm_left     = 0;
        results_seen  = 0;
        pressure_done = 1'b0;
        result_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (result_ch.valid && result_ch.ready) begin
                got.idx  = result_ch.target_index;
                got.tx   = result_ch.tangent_x;
                got.ty   = result_ch.tangent_y;
                got.tz   = result_ch.tangent_z;
                got.deg  = result_ch.degenerate;
                got.last = result_ch.last_of_triangle;
                check_tangent(got);
                results_seen++;
            end
            // hold off long enough for the block to back up into its input
            if (!pressure_done && results_seen >= PRESSURE_AFTER) begin
                pressure_done = 1'b1;
                stall_left    = PRESSURE_CYCLES;
                calm_left     = 0;
            end
            if (stall_left > 0) begin
                result_ch.ready <= 1'b0;
                stall_left--;
            end
            else if (calm_left > 0) begin
                result_ch.ready <= 1'b1;
                calm_left--;
            end
            else begin
                roll = $urandom_range(0, 99);
                if (roll < 4) begin
                    calm_left = $urandom_range(40, 150);
                    result_ch.ready <= 1'b1;
                end
                else if (roll < 70) begin
                    result_ch.ready <= 1'b1;
                end
                else if (roll < 95) begin
                    stall_left = $urandom_range(1, 3) - 1;
                    result_ch.ready <= 1'b0;
                end
                else begin
                    stall_left = $urandom_range(10, 40) - 1;
                    result_ch.ready <= 1'b0;
                end
            end
        end
    end

    // corner side: reset, directed table, random triangles, drain, verdict
    initial begin : stimulus
        triangle_row_t directed_rows[8];
        corner_t       tri_corners[3];
        logic signed [31:0] step_u, step_v;
        int  r, t, k, kind, pmode, umode;
        bit  burst;
        logic [31:0] base_idx;

        rst_n                  <= 1'b0;
        corner_ch.valid        <= 1'b0;
        corner_ch.corner_index <= '0;
        corner_ch.pos_x        <= '0;
        corner_ch.pos_y        <= '0;
        corner_ch.pos_z        <= '0;
        corner_ch.tex_u        <= '0;
        corner_ch.tex_v        <= '0;

        // unit x tangent straight after reset
        directed_rows[0] = '{make_corner(32'd0, 0, 0, 0, 0, 0),
                             make_corner(32'd1, ONE_Q16, 0, 0, ONE_Q16, 0),
                             make_corner(32'd2, 0, ONE_Q16, 0, 0, ONE_Q16),
                             1'b1, tangent_t'{UNIT_POS, 16'sd0, 16'sd0, 1'b0}};
        // unit y tangent
        directed_rows[1] = '{make_corner(32'd10, 0, 0, 0, 0, 0),
                             make_corner(32'd11, 0, ONE_Q16, 0, ONE_Q16, 0),
                             make_corner(32'd12, 0, 0, ONE_Q16, 0, ONE_Q16),
                             1'b1, tangent_t'{16'sd0, UNIT_POS, 16'sd0, 1'b0}};
        // mirrored u flips the sign; index extremes
        directed_rows[2] = '{make_corner(32'hffff_ffff, 0, 0, 0, 0, 0),
                             make_corner(32'h0000_0000, 0, 0, ONE_Q16, -ONE_Q16, 0),
                             make_corner(32'h8000_0000, ONE_Q16, 0, 0, 0, ONE_Q16),
                             1'b1, tangent_t'{16'sd0, 16'sd0, UNIT_NEG, 1'b0}};
        // all three uv equal: zero determinant
        directed_rows[3] = '{make_corner(32'd30, 3 * ONE_Q16, -2 * ONE_Q16, 7 * ONE_Q16,
                                         5 * ONE_Q16, 5 * ONE_Q16),
                             make_corner(32'd31, -ONE_Q16, 4 * ONE_Q16, 0,
                                         5 * ONE_Q16, 5 * ONE_Q16),
                             make_corner(32'd32, 0, ONE_Q16, -9 * ONE_Q16,
                                         5 * ONE_Q16, 5 * ONE_Q16),
                             1'b1, tangent_t'{16'sd0, 16'sd0, 16'sd0, 1'b1}};
        // collinear uv: zero determinant
        directed_rows[4] = '{make_corner(32'd40, 0, 0, 0, 0, 0),
                             make_corner(32'd41, ONE_Q16, 0, 0, ONE_Q16, ONE_Q16),
                             make_corner(32'd42, 0, ONE_Q16, 0, 2 * ONE_Q16, 2 * ONE_Q16),
                             1'b1, tangent_t'{16'sd0, 16'sd0, 16'sd0, 1'b1}};
        // coincident corners: good uv, but the vector is zero
        directed_rows[5] = '{make_corner(32'd50, COORD_MAX, COORD_MIN, 0, 0, 0),
                             make_corner(32'd51, COORD_MAX, COORD_MIN, 0, ONE_Q16, 0),
                             make_corner(32'd52, COORD_MAX, COORD_MIN, 0, 0, ONE_Q16),
                             1'b1, tangent_t'{16'sd0, 16'sd0, 16'sd0, 1'b1}};
        // full-scale positions and texture coordinates
        directed_rows[6] = '{make_corner(32'd60, COORD_MIN, COORD_MIN, COORD_MIN,
                                         COORD_MIN, COORD_MIN),
                             make_corner(32'd61, COORD_MAX, COORD_MAX, COORD_MAX,
                                         COORD_MAX, COORD_MIN),
                             make_corner(32'd62, COORD_MIN, COORD_MAX, COORD_MIN,
                                         COORD_MIN, COORD_MAX),
                             1'b0, tangent_t'('0)};
        directed_rows[7] = '{make_corner(32'd70, COORD_MAX, 0, COORD_MIN,
                                         COORD_MAX, COORD_MAX),
                             make_corner(32'd71, COORD_MIN, COORD_MAX, 0,
                                         COORD_MIN, COORD_MAX),
                             make_corner(32'd72, 0, COORD_MIN, COORD_MAX,
                                         COORD_MAX, COORD_MIN),
                             1'b0, tangent_t'('0)};

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed triangles, gaps at random
        for (r = 0; r < 8; r++) begin
            push_corner(directed_rows[r].c0, sender_gap(), 1'b0, tangent_t'('0));
            push_corner(directed_rows[r].c1, sender_gap(), 1'b0, tangent_t'('0));
            push_corner(directed_rows[r].c2, sender_gap(), directed_rows[r].typed,
                        directed_rows[r].want);
        end

        // random triangles of mixed shape
        for (t = 0; t < RANDOM_TRIANGLES; t++) begin
            kind     = $urandom_range(0, 99);
            pmode    = $urandom_range(0, 2);
            umode    = $urandom_range(0, 2);
            base_idx = $urandom;
            if (kind < 15) begin
                // every bit free
                pmode = 0;
                umode = 0;
            end
            for (k = 0; k < 3; k++) begin
                tri_corners[k].idx = ($urandom_range(0, 3) == 0) ? base_idx + k : $urandom;
                tri_corners[k].px  = rand_coord(pmode);
                tri_corners[k].py  = rand_coord(pmode);
                tri_corners[k].pz  = rand_coord(pmode);
                tri_corners[k].tu  = rand_coord(umode);
                tri_corners[k].tv  = rand_coord(umode);
            end
            if (kind >= 70 && kind < 80) begin
                // identical uv on all corners
                for (k = 1; k < 3; k++) begin
                    tri_corners[k].tu = tri_corners[0].tu;
                    tri_corners[k].tv = tri_corners[0].tv;
                end
            end
            else if (kind >= 80 && kind < 87) begin
                // uv on one line: equal steps from the first corner
                step_u = rand_coord(1);
                step_v = rand_coord(1);
                tri_corners[0].tu = rand_coord(1);
                tri_corners[0].tv = rand_coord(1);
                tri_corners[1].tu = tri_corners[0].tu + step_u;
                tri_corners[1].tv = tri_corners[0].tv + step_v;
                tri_corners[2].tu = tri_corners[0].tu + 2 * step_u;
                tri_corners[2].tv = tri_corners[0].tv + 2 * step_v;
            end
            else if (kind >= 87 && kind < 93) begin
                // all corners at one point
                for (k = 1; k < 3; k++) begin
                    tri_corners[k].px = tri_corners[0].px;
                    tri_corners[k].py = tri_corners[0].py;
                    tri_corners[k].pz = tri_corners[0].pz;
                end
            end
            // some triangles go back to back
            burst = ($urandom_range(0, 4) == 0);
            for (k = 0; k < 3; k++)
                push_corner(tri_corners[k], burst ? 0 : sender_gap(), 1'b0, tangent_t'('0));
        end
        corner_ch.valid <= 1'b0;

        // let every expected item arrive, then watch for strays
        while (pending_tangents.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && pending_tangents.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // hang guard
    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: triangle_tangent_generator.f
rtl/core/ttg_pkg.sv
rtl/core/ttg_corner_if.sv
rtl/core/ttg_result_if.sv
rtl/core/ttg_norm.sv
rtl/core/triangle_tangent_generator.sv
tb/sv/tb_triangle_tangent_generator.sv
